// ===== rtl/aes_pkg.sv =====
// AES package: cipher constants, S-box tables and round functions.
// Used by the AES core and the top level. No dependencies.
`timescale 1ns / 1ps
package aes_pkg;

  localparam int ROUNDS_DEF = 10;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CFB = 2'd2;
  localparam logic [1:0] MODE_OFB = 2'd3;

  localparam logic [7:0] POLY_RED = 8'h1b;
  localparam logic [7:0] MSB_MASK = 8'h80;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (((a & MSB_MASK) != 8'h00) ? POLY_RED : 8'h00);
  endfunction

  // byte n of a block: bits [127-8n -: 8]
  function automatic logic [7:0] byte_of(input block_t s, input int n);
    byte_of = s[127-8*n -: 8];
  endfunction

  function automatic block_t fwd_round(input block_t s, input logic last);
    block_t t;
    block_t m;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    m = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[byte_of(s, r + 4*((c + r) & 3))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(t, 4*c);
      a1 = byte_of(t, 4*c+1);
      a2 = byte_of(t, 4*c+2);
      a3 = byte_of(t, 4*c+3);
      m[127-32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                           a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                           a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                           xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    end
    fwd_round = last ? t : m;
  endfunction

  // inverse shift and substitute
  function automatic block_t inv_sub(input block_t s);
    block_t t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*((c + r) & 3)) -: 8] = ISBOX[byte_of(s, r + 4*c)];
      end
    end
    inv_sub = t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t m;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    m = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = byte_of(s, 4*c+j);
        x2[j] = xt(a[j]);
        x4[j] = xt(x2[j]);
        x8[j] = xt(x4[j]);
        m9[j] = x8[j] ^ a[j];
        mb[j] = x8[j] ^ x2[j] ^ a[j];
        md[j] = x8[j] ^ x4[j] ^ a[j];
        me[j] = x8[j] ^ x4[j] ^ x2[j];
      end
      m[127-32*c -: 32] = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                           m9[0] ^ me[1] ^ mb[2] ^ md[3],
                           md[0] ^ m9[1] ^ me[2] ^ mb[3],
                           mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    end
    inv_mix = m;
  endfunction

endpackage

// ===== rtl/aes_core.sv =====
// AES round engine: round key memory, key expansion and one round per cycle.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_core #(
  parameter int ROUNDS = aes_pkg::ROUNDS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           dec,
  input  logic           expand,
  input  logic [127:0]   key,
  input  aes_pkg::block_t blk_in,
  output logic           done,
  output aes_pkg::block_t blk_out
);
  import aes_pkg::*;

  localparam int NRK = ROUNDS + 1;
  localparam int RW  = $clog2(NRK + 1);
  localparam int AW  = $clog2(NRK);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXP  = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // round key memory: one 128-bit round key per entry
  logic [127:0] rk_mem [NRK];
  logic [127:0] rk_rd_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [127:0]  wr_data;

  logic [2:0]    state_r, state_nxt;
  logic [RW-1:0] cnt_r, cnt_nxt;
  logic          dec_r, dec_nxt;
  logic [127:0]  st_r, st_nxt;
  logic [127:0]  kw_r, kw_nxt;
  logic [7:0]    rc_r, rc_nxt;
  logic [31:0]   tw;
  logic [127:0]  kn;
  logic [127:0]  after_rnd;
  logic          last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rk_mem[wr_addr] <= wr_data;
    end
    rk_rd_r <= rk_mem[rd_addr];
  end

  // next round key from the current one
  always_comb begin
    tw = {SBOX[kw_r[23:16]], SBOX[kw_r[15:8]], SBOX[kw_r[7:0]], SBOX[kw_r[31:24]]}
         ^ {rc_r, 24'h0};
    kn[127:96] = kw_r[127:96] ^ tw;
    kn[95:64]  = kw_r[95:64] ^ kn[127:96];
    kn[63:32]  = kw_r[63:32] ^ kn[95:64];
    kn[31:0]   = kw_r[31:0] ^ kn[63:32];
  end

  always_comb begin
    last = (cnt_r == RW'(ROUNDS));
    if (dec_r) begin
      after_rnd = last ? (inv_sub(st_r) ^ rk_rd_r) : inv_mix(inv_sub(st_r) ^ rk_rd_r);
    end else begin
      after_rnd = fwd_round(st_r, last) ^ rk_rd_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    st_nxt    = st_r;
    kw_nxt    = kw_r;
    rc_nxt    = rc_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[AW-1:0];
    wr_data   = kw_r;
    rd_addr   = '0;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          dec_nxt = dec;
          st_nxt  = blk_in;
          cnt_nxt = '0;
          kw_nxt  = key;
          rc_nxt  = 8'h01;
          state_nxt = expand ? S_EXP : S_PRE;
          rd_addr = dec ? AW'(ROUNDS) : '0;
        end
      end
      S_EXP: begin
        // write one round key per cycle
        wr_en   = 1'b1;
        kw_nxt  = kn;
        rc_nxt  = xt(rc_r);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RW'(ROUNDS)) begin
          // hold the final round key for forwarding in S_PRE
          kw_nxt    = kw_r;
          cnt_nxt   = '0;
          state_nxt = S_PRE;
        end
        rd_addr = dec_r ? AW'(ROUNDS) : '0;
      end
      S_PRE: begin
        // initial key addition
        st_nxt  = st_r ^ rk_rd_r;
        cnt_nxt = RW'(1);
        rd_addr = dec_r ? AW'(ROUNDS - 1) : AW'(1);
        state_nxt = S_RND;
      end
      S_RND: begin
        st_nxt  = after_rnd;
        cnt_nxt = cnt_r + 1'b1;
        rd_addr = dec_r ? AW'(RW'(ROUNDS - 1) - cnt_r) : AW'(cnt_r + 1'b1);
        if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // S_EXP reads address 0/ROUNDS on its last cycle; the entry was already written
  // unless it is the final one, which is written in that same cycle: forward it.
  logic fwd_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fwd_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fwd_last_r <= wr_en && (wr_addr == rd_addr);
    end
    cnt_r <= cnt_nxt;
    dec_r <= dec_nxt;
    kw_r  <= kw_nxt;
    rc_r  <= rc_nxt;
    if (state_r == S_PRE && fwd_last_r) begin
      st_r <= st_r ^ kw_r;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign blk_out = st_r;

endmodule

// ===== rtl/aes128_block_cipher_modes.sv =====
// AES-128 with ECB/CBC/CFB/OFB chaining; top level with register file and chaining.
// Request accept to result valid: initial key addition, the rounds, then a done state;
// after reset or a key write, key expansion runs first.
// One request at a time: the next is taken the cycle after the result leaves, so a new
// request is not accepted until the previous result has been taken.
// Synchronous active-low reset clears control, chaining value and config registers; uses aes_pkg.
`timescale 1ns / 1ps
module aes128_block_cipher_modes #(
  parameter int ROUNDS = aes_pkg::ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic                          in_restart,
  input  logic [63:0]                   in_data_high,
  input  logic [63:0]                   in_data_low,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [63:0]                   out_result_high,
  output logic [63:0]                   out_result_low
);
  import aes_pkg::*;

  logic [127:0] key_r, iv_r, cv_r, din_r, cvu_r;
  logic [1:0]   mode_r;
  logic         kexp_r, busy_r, dec_r;
  logic         start, done;
  block_t       core_in, core_out;
  logic [127:0] cv_use, res;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      iv_r   <= '0;
      mode_r <= MODE_ECB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH: key_r[127:64] <= cfg_data;
        REG_KEY_LOW:  key_r[63:0]   <= cfg_data;
        REG_IV_HIGH:  iv_r[127:64]  <= cfg_data;
        REG_IV_LOW:   iv_r[63:0]    <= cfg_data;
        REG_MODE:     mode_r        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !busy_r && !out_valid;
  assign start    = in_valid && in_ready;
  assign cv_use   = in_restart ? iv_r : cv_r;

  // select cipher input by mode
  always_comb begin
    case (mode_r)
      MODE_ECB: core_in = {in_data_high, in_data_low};
      MODE_CBC: core_in = in_opcode ? {in_data_high, in_data_low}
                                    : ({in_data_high, in_data_low} ^ cv_use);
      default:  core_in = cv_use;
    endcase
  end

  aes_core #(.ROUNDS(ROUNDS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .dec    (in_opcode && (mode_r == MODE_ECB || mode_r == MODE_CBC)),
    .expand (!kexp_r),
    .key    (key_r),
    .blk_in (core_in),
    .done   (done),
    .blk_out(core_out)
  );

  always_comb begin
    case (mode_r)
      MODE_ECB: res = core_out;
      MODE_CBC: res = dec_r ? (core_out ^ cvu_r) : core_out;
      default:  res = core_out ^ din_r;
    endcase
  end

  // hold request, chain value and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_valid <= 1'b0;
      kexp_r    <= 1'b0;
      cv_r      <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)) begin
        kexp_r <= 1'b0;
      end else if (start) begin
        kexp_r <= 1'b1;
      end
      if (start) begin
        busy_r <= 1'b1;
        if (in_restart) begin
          cv_r <= iv_r;
        end
      end
      if (done) begin
        busy_r    <= 1'b0;
        out_valid <= 1'b1;
        case (mode_r)
          MODE_ECB: ;
          MODE_CBC: cv_r <= dec_r ? din_r : core_out;
          MODE_CFB: cv_r <= dec_r ? din_r : res;
          default:  cv_r <= core_out;
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (start) begin
      din_r <= {in_data_high, in_data_low};
      cvu_r <= cv_use;
      dec_r <= in_opcode;
    end
    if (done) begin
      out_result_high <= res[127:64];
      out_result_low  <= res[63:0];
    end
  end

endmodule

// ===== rtl/aes128_block_cipher_modes_chk.sv =====
// Port-level checker for the AES chaining block, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module aes128_block_cipher_modes_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] out_result_high
);
  // no new request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  // result never follows a request the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // busy after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_high)))
    else $error("result dropped");
endmodule

bind aes128_block_cipher_modes aes128_block_cipher_modes_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_result_high(out_result_high)
);
